@@ rtl/psd_pkg.sv @@
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants and types for the point to segment squared distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

  // default coordinate width, signed, 4 fraction bits
  localparam int COORD_WIDTH = 20;
  // fraction bits of the projection parameter t
  localparam int T_FRAC_BITS = 16;
  // width of the squared distance result, 8 fraction bits
  localparam int OUT_WIDTH   = 48;

  // how the divider pipeline forms t
  typedef struct packed {
    logic div;   // t comes from the quotient
    logic one;   // t is exactly 1.0 (when not div)
  } psd_mode_t;

endpackage

@@ rtl/psd_divider.sv @@
// ----------------------------------------------------------------------------
// psd_divider
// Pipelined restoring divider, one quotient bit per stage, forming the
// clamped projection parameter t. Side data travels along with each item.
// ----------------------------------------------------------------------------
module psd_divider #(
  parameter int NW = 44,
  parameter int TF = psd_pkg::T_FRAC_BITS,
  parameter int SW = 126
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [NW-1:0]        num,
  input  logic [NW-1:0]        den,
  input  psd_pkg::psd_mode_t   mode,
  input  logic [SW-1:0]        side_in,
  output logic                 out_vld,
  output logic [TF:0]          t,
  output logic [SW-1:0]        side_out
);

  logic [NW-1:0]       rem  [0:TF];
  logic [NW-1:0]       dv   [0:TF];
  logic [TF-1:0]       q    [0:TF];
  psd_pkg::psd_mode_t  md   [0:TF];
  logic [SW-1:0]       sd   [0:TF];
  logic                vld  [0:TF];

  assign rem[0] = num;
  assign dv[0]  = den;
  assign q[0]   = '0;
  assign md[0]  = mode;
  assign sd[0]  = side_in;
  assign vld[0] = in_vld;

  for (genvar k = 0; k < TF; k++) begin : g_stage
    logic [NW-1:0] sh;
    logic          ge;

    // shift, compare, subtract: one quotient bit
    assign sh = {rem[k][NW-2:0], 1'b0};
    assign ge = (sh >= dv[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? (sh - dv[k]) : sh;
        q[k+1]   <= {q[k][TF-2:0], ge};
        dv[k+1]  <= dv[k];
        md[k+1]  <= md[k];
        sd[k+1]  <= sd[k];
      end
    end
  end

  // select quotient or a clamped end value
  always_comb begin
    if (md[TF].div) begin
      t = {1'b0, q[TF]};
    end else if (md[TF].one) begin
      t = {1'b1, {TF{1'b0}}};
    end else begin
      t = '0;
    end
  end

  assign out_vld  = vld[TF];
  assign side_out = sd[TF];

endmodule

@@ rtl/point_segment_distance_sq.sv @@
// ----------------------------------------------------------------------------
// point_segment_distance_sq
// Squared distance from a 3D point to a 3D segment, fixed point.
// ----------------------------------------------------------------------------
// Input channel s_*: one transaction carries point P, segment start A and
// segment end B, nine signed coordinates with 4 fraction bits.
// Output channel m_*: one transaction per input, the squared distance with
// 8 fraction bits, saturated to the output width.
// Pipeline stages: three stages form the dot products, T_FRAC_BITS stages of
// the restoring divider produce t one bit each, four stages form the residual,
// its squares and the rounded sum.
// Throughput is one transaction per cycle; the whole pipeline advances
// together whenever the output register is empty or being taken.
// When the receiver stalls with a result waiting, the pipeline holds and
// s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits; the block accepts input in the next cycle.
// ----------------------------------------------------------------------------
module point_segment_distance_sq #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH,
  parameter int T_FRAC_BITS = psd_pkg::T_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // distance_sq
  output logic [psd_pkg::OUT_WIDTH-1:0]          m_tdata
);

  localparam int CW  = COORD_WIDTH;
  localparam int TF  = T_FRAC_BITS;
  localparam int OW  = psd_pkg::OUT_WIDTH;
  localparam int AW  = CW + 1;
  localparam int PW  = 2 * AW;
  localparam int NW  = PW + 2;
  localparam int TW  = TF + 1;
  localparam int DW  = AW + TF + 2;
  localparam int RS  = TF - 4;
  localparam int MW  = DW - RS;
  localparam int SQW = 2 * MW;
  localparam int SMW = SQW + 3;
  localparam int RW  = (SMW - 8 > OW) ? SMW - 8 : OW + 1;
  localparam int SW  = 6 * AW;

  logic en;

  // ---- stage 1: differences ----
  logic                 v1;
  logic signed [AW-1:0] ab1 [0:2];
  logic signed [AW-1:0] ap1 [0:2];

  // ---- stage 2: products ----
  logic                 v2;
  logic signed [PW-1:0] apab2 [0:2];
  logic signed [PW-1:0] abab2 [0:2];
  logic signed [AW-1:0] ab2 [0:2];
  logic signed [AW-1:0] ap2 [0:2];

  // ---- stage 3: dot products ----
  logic                 v3;
  logic signed [NW-1:0] num3;
  logic signed [NW-1:0] den3;
  logic signed [AW-1:0] ab3 [0:2];
  logic signed [AW-1:0] ap3 [0:2];

  // ---- divider ----
  psd_pkg::psd_mode_t   mode3;
  logic [SW-1:0]        side3;
  logic [SW-1:0]        side4;
  logic                 v4;
  logic [TW-1:0]        t4;
  logic signed [AW-1:0] ab4 [0:2];
  logic signed [AW-1:0] ap4 [0:2];

  // ---- stage 5..8 ----
  logic                 v5;
  logic signed [DW-1:0] tab5 [0:2];
  logic signed [AW-1:0] ap5  [0:2];
  logic                 v6;
  logic [MW-1:0]        m6   [0:2];
  logic                 v7;
  logic [SQW-1:0]       sq7  [0:2];

  logic [SMW-1:0]       sum8;
  logic [RW-1:0]        res8;

  // whole pipeline advances while the output can move
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v5       <= 1'b0;
      v6       <= 1'b0;
      v7       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      v5       <= v4;
      v6       <= v5;
      v7       <= v6;
      m_tvalid <= v7;
    end
  end

  // per-axis datapath
  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [CW-1:0]    p, a, b;
    logic signed [TW+AW:0]   tab;
    logic signed [DW-1:0]    diff;
    logic [DW-1:0]           mag;
    logic [DW-1:0]           rnd;

    assign p = s_tdata[i*CW +: CW];
    assign a = s_tdata[(3+i)*CW +: CW];
    assign b = s_tdata[(6+i)*CW +: CW];

    assign ab4[i] = side4[i*AW +: AW];
    assign ap4[i] = side4[(3+i)*AW +: AW];

    assign tab  = $signed({1'b0, t4}) * ab4[i];
    assign diff = (DW'(ap5[i]) <<< TF) - tab5[i];
    assign mag  = diff[DW-1] ? (DW'(0) - diff) : diff;
    assign rnd  = mag + (DW'(1) << (RS - 1));

    always_ff @(posedge clk) begin
      if (en) begin
        ab1[i]   <= AW'(b) - AW'(a);
        ap1[i]   <= AW'(p) - AW'(a);
        apab2[i] <= ap1[i] * ab1[i];
        abab2[i] <= ab1[i] * ab1[i];
        ab2[i]   <= ab1[i];
        ap2[i]   <= ap1[i];
        ab3[i]   <= ab2[i];
        ap3[i]   <= ap2[i];
        tab5[i]  <= DW'(tab);
        ap5[i]   <= ap4[i];
        m6[i]    <= rnd[DW-1:RS];
        sq7[i]   <= MW'(m6[i]) * MW'(m6[i]) ;
      end
    end
  end

  // dot products
  always_ff @(posedge clk) begin
    if (en) begin
      num3 <= NW'(apab2[0]) + NW'(apab2[1]) + NW'(apab2[2]);
      den3 <= NW'(abab2[0]) + NW'(abab2[1]) + NW'(abab2[2]);
    end
  end

  // clamp decisions: degenerate or before start gives 0, past end gives 1
  always_comb begin
    mode3.div = 1'b0;
    mode3.one = 1'b0;
    if (den3 == '0 || num3 <= NW'(0)) begin
      mode3.div = 1'b0;
    end else if (num3 >= den3) begin
      mode3.one = 1'b1;
    end else begin
      mode3.div = 1'b1;
    end
  end

  assign side3 = {ap3[2], ap3[1], ap3[0], ab3[2], ab3[1], ab3[0]};

  psd_divider #(
    .NW (NW),
    .TF (TF),
    .SW (SW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v3),
    .num      (num3),
    .den      (den3),
    .mode     (mode3),
    .side_in  (side3),
    .out_vld  (v4),
    .t        (t4),
    .side_out (side4)
  );

  // rounded sum and saturation
  assign sum8 = SMW'(sq7[0]) + SMW'(sq7[1]) + SMW'(sq7[2]) + SMW'(128);
  assign res8 = RW'(sum8[SMW-1:8]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (res8 > RW'({OW{1'b1}})) begin
        m_tdata <= {OW{1'b1}};
      end else begin
        m_tdata <= res8[OW-1:0];
      end
    end
  end

endmodule

@@ rtl/psd_checker.sv @@
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks for point_segment_distance_sq, bound to the top level.
// ----------------------------------------------------------------------------
module psd_checker #(
  parameter int IW = ((9*psd_pkg::COORD_WIDTH+7)/8)*8
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [IW-1:0]                 s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [psd_pkg::OUT_WIDTH-1:0] m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");

  // reset leaves no result valid
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // empty output register never blocks input
  a_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // a taken result frees the pipeline
  a_take: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input blocked while output drains");

endmodule

bind point_segment_distance_sq psd_checker #(
  .IW (((9*COORD_WIDTH+7)/8)*8)
) u_psd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/sv/point_segment_distance_sq_tb.sv @@
// ----------------------------------------------------------------------------
// point_segment_distance_sq_tb
// Self-checking bench for the point to segment squared distance block.
// Drives directed and random geometry queries through the input stream,
// predicts each squared distance in fixed point and checks the output stream
// in order, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module point_segment_distance_sq_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW    = psd_pkg::COORD_WIDTH;
  localparam int TF    = psd_pkg::T_FRAC_BITS;
  localparam int OW    = psd_pkg::OUT_WIDTH;
  localparam int DW    = ((9*CW+7)/8)*8;
  localparam int LAT   = TF + 7;
  localparam int NRAND = 1900;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [OW-1:0] dist_t;

  // scoreboard: queue of predicted squared distances
  class dist_scoreboard;
    dist_t pending_dist[$];
    int    n_in, n_out, n_err;

    function void note_query(coord_t c[9]);
      longint signed ab[3], ap[3], num, den, diff;
      longint unsigned t, rem, m, sum, res;
      num = 0; den = 0; sum = 0;
      for (int i = 0; i < 3; i++) begin
        ab[i] = longint'(c[6+i]) - longint'(c[3+i]);
        ap[i] = longint'(c[i]) - longint'(c[3+i]);
        num += ap[i] * ab[i];
        den += ab[i] * ab[i];
      end
      // clamp t to 0..1, else long division
      if (den == 0 || num <= 0) t = 0;
      else if (num >= den) t = 64'd1 << TF;
      else begin
        rem = num; t = 0;
        for (int i = 0; i < TF; i++) begin
          rem = rem << 1; t = t << 1;
          if (rem >= den) begin
            rem -= den; t |= 1;
          end
        end
      end
      // per-axis residual, rounded to 8 fraction bits, then squared
      for (int i = 0; i < 3; i++) begin
        diff = (ap[i] <<< TF) - longint'(t) * ab[i];
        m = (diff < 0) ? -diff : diff;
        m = (m + (64'd1 << (TF-5))) >> (TF-4);
        sum += m * m;
      end
      res = (sum + 128) >> 8;
      if (res > {OW{1'b1}}) res = {OW{1'b1}};
      pending_dist = {pending_dist, res[OW-1:0]};
      n_in++;
    endfunction

    task check_dist(dist_t got);
      dist_t want;
      n_out++;
      if (pending_dist.size() == 0) begin
        report_err($sformatf("unexpected result %0d", got));
        return;
      end
      want = pending_dist.pop_front();
      if (got !== want)
        report_err($sformatf("distance_sq got %0d want %0d", got, want));
    endtask

    task report_err(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      n_err++;
    endtask
  endclass

  logic          clk = 0;
  logic          rst = 1;
  logic          s_tvalid = 0;
  logic          s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 0;
  dist_t         m_tdata;

  dist_scoreboard sb = new();
  int  src_idle_pct = 0, snk_stall_pct = 0;
  bit  hold_off = 0;
  int  n_hold_cycles = 0;

  always #10 clk = ~clk;

  point_segment_distance_sq uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_dist(m_tdata);
    if (rst) m_tready <= 0;
    else if (hold_off) begin
      m_tready <= 0;
      n_hold_cycles++;
    end else m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // one query: pack fields, optional idle gap, wait for acceptance
  task automatic send_query(coord_t c[9]);
    logic [DW-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*CW +: CW] = c[i];
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_query(c);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(64) - 32);
      2: return coord_t'($urandom_range(8000) - 4000);
      default: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
    endcase
  endfunction

  task automatic rand_query();
    coord_t c[9];
    int mode, kind;
    mode = $urandom_range(3);
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) c[i] = rand_coord(mode == 3 ? $urandom_range(3) : mode);
    if (kind == 0) for (int i = 0; i < 3; i++) c[6+i] = c[3+i];        // zero-length
    else if (kind == 1) for (int i = 0; i < 3; i++) c[i] = c[3+i];     // P on A
    else if (kind == 2) for (int i = 0; i < 3; i++) c[i] = c[6+i];     // P on B
    send_query(c);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending_dist.size() != 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  initial begin
    #50_000_000;
    $display("** point_segment_distance_sq: FAILED **");
    $finish;
  end

  initial begin
    coord_t c[9];
    coord_t mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, zero-length, before start, past end, inside
    foreach (c[i]) c[i] = 0;
    send_query(c);
    foreach (c[i]) c[i] = mx;
    send_query(c);
    foreach (c[i]) c[i] = mn;
    send_query(c);
    c = '{mx, mx, mx, mn, mn, mn, mn, mn, mn};
    send_query(c);
    c = '{mn, mn, mn, mx, mx, mx, mx, mx, mx};
    send_query(c);
    c = '{mx, mn, mx, mn, mx, mn, mx, mn, mx};
    send_query(c);
    c = '{mn, mx, mn, mx, mn, mx, mn, mx, mn};
    send_query(c);
    c = '{-16, 0, 0, 0, 0, 0, 160, 0, 0};   // before start
    send_query(c);
    c = '{320, 5, 0, 0, 0, 0, 160, 0, 0};   // past end
    send_query(c);
    c = '{160, 0, 0, 0, 0, 0, 160, 0, 0};   // exactly at end
    send_query(c);
    c = '{80, 32, -7, 0, 0, 0, 160, 0, 0};  // inside
    send_query(c);
    c = '{50, 17, 3, 1, 2, 3, 7, -11, 29};
    send_query(c);
    c = '{33, -9, 12, 4, 4, 4, 4, 4, 4};    // zero-length
    send_query(c);
    c = '{1, 1, 1, 0, 0, 0, 3, 3, 3};       // t = 1/3
    send_query(c);
    c = '{mx, 0, 0, mn, 0, 0, mn, 0, 0};    // zero-length, far point
    send_query(c);
    c = '{0, mx, 0, mn, mn, mn, mx, mx, mx};
    send_query(c);
    drain();

    // random phases with varying idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
        default: begin src_idle_pct = 30; snk_stall_pct = 30; end
      endcase
      for (int n = 0; n < NRAND/4; n++) begin
        rand_query();
      end
      drain();
    end

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        repeat (40) rand_query();
        s_tvalid <= 0;
      end
      begin
        int k;
        k = 0;
        hold_off = 1;
        while (k < 3 * LAT + 20) begin
          @(posedge clk);
          k++;
        end
        hold_off = 0;
      end
    join
    drain();

    $display("Covered %0d queries (%0d results), incl. degenerate and clamped segments,",
             sb.n_in, sb.n_out);
    $display("under four idling mixes and a %0d-cycle receiver hold-off.", n_hold_cycles);
    if (sb.n_err == 0 && sb.pending_dist.size() == 0)
      $display("** point_segment_distance_sq: PASSED **");
    else
      $display("** point_segment_distance_sq: FAILED **");
    $finish;
  end
endmodule
